// ===== rtl/pts_pkg.sv =====
// Shared types, codes and constants for the periodic timer slot table.
// Used by pts_ctrl, pts_dp and periodic_timer_slot_table; depends on nothing.
`default_nettype none

package pts_pkg;

    // Table size default and result cap per tick
    localparam int SLOT_COUNT_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int CNT_W          = 5;
    localparam int DIV_STEPS      = 32;
    localparam int DIV_CNT_W      = 6;

    // Input item kinds
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_OK   = 2'd0;
    localparam logic [1:0] KIND_FAIL = 2'd1;
    localparam logic [1:0] KIND_FIRE = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] callback_addr;
        logic [31:0] delay;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
        logic [31:0] arg_c;
        logic [31:0] arg_d;
        logic [4:0]  slot_index;
        logic [31:0] task_process;
        logic [31:0] task_thread;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] fire_addr;
        logic [31:0] fire_a;
        logic [31:0] fire_b;
        logic [31:0] fire_c;
        logic [31:0] fire_d;
        logic        last;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_DIV,
        S_ASCAN,
        S_ARESP,
        S_TRD,
        S_TEV,
        S_TFIN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_step;
        logic scan_clr;
        logic scan_adv;
        logic tick_inc;
        logic add_write;
        logic remove_clr;
        logic resp_fail;
        logic push_resp;
        logic fire_take;
        logic push_last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       reject;
        logic       div_done;
        logic       free_hit;
        logic       fire_hit;
        logic       idx_end;
        logic       cnt_last;
        logic       hold_v;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/pts_ctrl.sv =====
// Sequencer for the timer slot table: decodes each word and steps the datapath.
// Depends on pts_pkg.
`default_nettype none

module pts_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire pts_pkg::sts_t sts,
    output pts_pkg::cmd_t      cmd
);

    pts_pkg::state_t state_reg;
    pts_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pts_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = pts_pkg::S_DEC;
            end
            pts_pkg::S_DEC:
            begin
                unique case (sts.mode)
                    pts_pkg::MODE_ADD:
                        state_next = sts.reject ? pts_pkg::S_ARESP : pts_pkg::S_DIV;
                    pts_pkg::MODE_TICK:
                        state_next = pts_pkg::S_TRD;
                    default:
                        state_next = pts_pkg::S_IDLE;
                endcase
            end
            pts_pkg::S_DIV:
            begin
                if (sts.div_done)
                    state_next = pts_pkg::S_ASCAN;
            end
            pts_pkg::S_ASCAN:
            begin
                if (sts.free_hit || sts.idx_end)
                    state_next = pts_pkg::S_ARESP;
            end
            pts_pkg::S_ARESP:
            begin
                if (sts.out_free)
                    state_next = pts_pkg::S_IDLE;
            end
            pts_pkg::S_TRD:
            begin
                state_next = pts_pkg::S_TEV;
            end
            pts_pkg::S_TEV:
            begin
                if (sts.fire_hit)
                begin
                    if (!sts.hold_v || sts.out_free)
                        state_next = (sts.idx_end || sts.cnt_last) ?
                                     pts_pkg::S_TFIN : pts_pkg::S_TRD;
                end
                else
                begin
                    state_next = sts.idx_end ? pts_pkg::S_TFIN : pts_pkg::S_TRD;
                end
            end
            pts_pkg::S_TFIN:
            begin
                if (!sts.hold_v || sts.out_free)
                    state_next = pts_pkg::S_IDLE;
            end
            default:
                state_next = pts_pkg::S_IDLE;
        endcase
    end

    // Drive commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            pts_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            pts_pkg::S_DEC:
            begin
                cmd.resp_fail = 1'b1;
                cmd.scan_clr  = 1'b1;
                cmd.div_start = (sts.mode == pts_pkg::MODE_ADD);
                cmd.tick_inc  = (sts.mode == pts_pkg::MODE_TICK);
                cmd.remove_clr = (sts.mode == pts_pkg::MODE_REMOVE);
            end
            pts_pkg::S_DIV:
            begin
                cmd.div_step = !sts.div_done;
            end
            pts_pkg::S_ASCAN:
            begin
                cmd.add_write = sts.free_hit;
                cmd.scan_adv  = !sts.free_hit && !sts.idx_end;
            end
            pts_pkg::S_ARESP:
            begin
                cmd.push_resp = sts.out_free;
            end
            pts_pkg::S_TEV:
            begin
                if (sts.fire_hit)
                begin
                    if (!sts.hold_v || sts.out_free)
                    begin
                        cmd.fire_take = 1'b1;
                        cmd.scan_adv  = !(sts.idx_end || sts.cnt_last);
                    end
                end
                else
                begin
                    cmd.scan_adv = !sts.idx_end;
                end
            end
            pts_pkg::S_TFIN:
            begin
                cmd.push_last = sts.hold_v && sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pts_dp.sv =====
// Datapath for the timer slot table: slot registers, argument memory, divider,
// scan counters, held fire and output register. Depends on pts_pkg.
`default_nettype none

module pts_dp #(
    parameter int SLOT_COUNT = pts_pkg::SLOT_COUNT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_data,
    input  wire pts_pkg::in_word_t in_word,
    input  wire pts_pkg::cmd_t     cmd,
    output pts_pkg::sts_t          sts,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pts_pkg::out_word_t     out_word
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [15:0]              tick_reg;
    logic [31:0]              now_reg;
    pts_pkg::in_word_t        in_reg;
    logic [31:0]              cb_reg  [SLOT_COUNT];
    logic [31:0]              per_reg [SLOT_COUNT];
    logic [31:0]              dl_reg  [SLOT_COUNT];
    logic [31:0]              proc_reg[SLOT_COUNT];
    logic [31:0]              thr_reg [SLOT_COUNT];
    logic [127:0]             args_mem[SLOT_COUNT];
    logic [127:0]             args_q_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [pts_pkg::CNT_W-1:0] cnt_reg;
    logic [16:0]              rem_reg;
    logic [31:0]              quo_reg;
    logic [pts_pkg::DIV_CNT_W-1:0] dcnt_reg;
    logic                     ok_reg;
    logic [IDX_W-1:0]         okslot_reg;
    logic                     hold_v_reg;
    logic [IDX_W-1:0]         hold_slot_reg;
    logic [31:0]              hold_addr_reg;
    logic [127:0]             hold_args_reg;
    logic                     out_valid_reg;
    pts_pkg::out_word_t       out_word_reg;

    logic [15:0] divisor;
    logic [16:0] rem_sh;
    logic [16:0] rem_sub;
    logic        rem_ge;
    logic [31:0] ticks;
    logic [31:0] cur_cb;
    logic [31:0] cur_dl;
    logic        out_free;
    logic [4:0]  hold_slot5;
    logic [4:0]  okslot5;
    logic [IDX_W-1:0] rm_idx;
    logic        rm_ok;

    // Divider step and rounded-up period
    assign divisor = (tick_reg == 16'd0) ? 16'd1 : tick_reg;
    assign rem_sh  = {rem_reg[15:0], quo_reg[31]};
    assign rem_ge  = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};
    assign ticks   = quo_reg + {31'd0, (rem_reg != 17'd0)};

    // Look at the slot under the scan pointer
    assign cur_cb   = cb_reg[idx_reg];
    assign cur_dl   = dl_reg[idx_reg];
    assign out_free = !out_valid_reg || out_ready;
    assign rm_idx   = in_reg.slot_index[IDX_W-1:0];
    assign rm_ok    = {1'b0, in_reg.slot_index} < 6'(SLOT_COUNT);

    assign sts.mode     = in_reg.mode;
    assign sts.reject   = (in_reg.callback_addr == 32'd0) || (in_reg.delay == 32'd0);
    assign sts.div_done = (dcnt_reg == pts_pkg::DIV_CNT_W'(pts_pkg::DIV_STEPS));
    assign sts.free_hit = (cur_cb == 32'd0) && (cur_dl == 32'd0);
    assign sts.fire_hit = (cur_cb != 32'd0) && (cur_dl <= now_reg)
                          && (proc_reg[idx_reg] == in_reg.task_process)
                          && (thr_reg[idx_reg] == in_reg.task_thread);
    assign sts.idx_end  = (idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign sts.cnt_last = (cnt_reg == pts_pkg::CNT_W'(pts_pkg::MAX_RESULTS - 1));
    assign sts.hold_v   = hold_v_reg;
    assign sts.out_free = out_free;

    // Hold configuration, tick counter, scan and divider state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= 16'd1;
            now_reg    <= 32'd0;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            dcnt_reg   <= '0;
            hold_v_reg <= 1'b0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tick_reg <= cfg_data;
            if (cmd.tick_inc)
                now_reg <= now_reg + 32'd1;
            if (cmd.scan_clr)
            begin
                idx_reg    <= '0;
                cnt_reg    <= '0;
                hold_v_reg <= 1'b0;
            end
            else if (cmd.scan_adv)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.fire_take)
            begin
                hold_v_reg <= 1'b1;
                cnt_reg    <= cnt_reg + pts_pkg::CNT_W'(1);
            end
            else if (cmd.push_last)
            begin
                hold_v_reg <= 1'b0;
            end
            if (cmd.div_start)
                dcnt_reg <= '0;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + pts_pkg::DIV_CNT_W'(1);
            if (cmd.resp_fail)
                ok_reg <= 1'b0;
            else if (cmd.add_write)
                ok_reg <= 1'b1;
        end
    end

    // Capture payload: input word, divider, held fire, add response slot
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= in_word;
        if (cmd.div_start)
        begin
            rem_reg <= 17'd0;
            quo_reg <= in_reg.delay;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub : rem_sh;
            quo_reg <= {quo_reg[30:0], rem_ge};
        end
        if (cmd.add_write)
            okslot_reg <= idx_reg;
        if (cmd.fire_take)
        begin
            hold_slot_reg <= idx_reg;
            hold_addr_reg <= cur_cb;
            hold_args_reg <= args_q_reg;
        end
    end

    // Slot table: write on add, clear on remove, rearm on fire
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                cb_reg[i]  <= 32'd0;
                per_reg[i] <= 32'd0;
                dl_reg[i]  <= 32'd0;
            end
        end
        else
        begin
            if (cmd.add_write)
            begin
                cb_reg[idx_reg]  <= in_reg.callback_addr;
                per_reg[idx_reg] <= ticks;
                dl_reg[idx_reg]  <= now_reg + ticks;
            end
            else if (cmd.fire_take)
            begin
                dl_reg[idx_reg] <= now_reg + per_reg[idx_reg];
            end
            else if (cmd.remove_clr && rm_ok)
            begin
                cb_reg[rm_idx] <= 32'd0;
                dl_reg[rm_idx] <= 32'd0;
            end
        end
    end

    // Owner registers and argument memory
    always_ff @(posedge clk)
    begin
        if (cmd.add_write)
        begin
            proc_reg[idx_reg] <= in_reg.task_process;
            thr_reg[idx_reg]  <= in_reg.task_thread;
            args_mem[idx_reg] <= {in_reg.arg_a, in_reg.arg_b, in_reg.arg_c, in_reg.arg_d};
        end
        args_q_reg <= args_mem[idx_reg];
    end

    assign hold_slot5 = 5'(hold_slot_reg);
    assign okslot5    = 5'(okslot_reg);

    // Output register: load a response or a fire, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_resp || cmd.push_last || (cmd.fire_take && hold_v_reg))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_resp)
        begin
            out_word_reg <= '{kind:      ok_reg ? pts_pkg::KIND_OK : pts_pkg::KIND_FAIL,
                              slot:      ok_reg ? okslot5[3:0] : 4'd0,
                              fire_addr: 32'd0,
                              fire_a:    32'd0,
                              fire_b:    32'd0,
                              fire_c:    32'd0,
                              fire_d:    32'd0,
                              last:      1'b1};
        end
        else if (cmd.push_last || (cmd.fire_take && hold_v_reg))
        begin
            out_word_reg.kind      <= pts_pkg::KIND_FIRE;
            out_word_reg.slot      <= hold_slot5[3:0];
            out_word_reg.fire_addr <= hold_addr_reg;
            out_word_reg.fire_a    <= hold_args_reg[127:96];
            out_word_reg.fire_b    <= hold_args_reg[95:64];
            out_word_reg.fire_c    <= hold_args_reg[63:32];
            out_word_reg.fire_d    <= hold_args_reg[31:0];
            out_word_reg.last      <= cmd.push_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

// ===== rtl/periodic_timer_slot_table.sv =====
// Top level of the periodic timer slot table: sequencer plus datapath.
// Depends on pts_pkg, pts_ctrl and pts_dp.
//
//   channel  | signals                      | carries
//   ---------+------------------------------+-------------------------------
//   in       | in_valid/in_ready/in_word    | add, remove or tick word
//   out      | out_valid/out_ready/out_word | add response or timer fire
//   cfg      | cfg_we/cfg_data              | tick_interval, no wait
//
// One word at a time. A remove clears on decode, a rejected add goes straight
// to its response, an add runs the one-bit-per-cycle divider, scans for a free
// slot and responds, and a tick reads argument memory, then compares, for each
// slot and waits out output stalls. Fires are held one deep so the final one
// can carry last. Reset clears the slot table at once; no clearing pass.
`default_nettype none

module periodic_timer_slot_table #(
    parameter int SLOT_COUNT = pts_pkg::SLOT_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pts_pkg::in_word_t  in_word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pts_pkg::out_word_t      out_word,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_data
);

    pts_pkg::cmd_t cmd;
    pts_pkg::sts_t sts;

    pts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pts_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // Add responses are always the only word of their item
    a_resp_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.kind != pts_pkg::KIND_FIRE) |-> out_word.last)
        else $error("add response without last");

    // A failed add reports slot zero
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.kind == pts_pkg::KIND_FAIL) |-> (out_word.slot == 4'd0))
        else $error("failed add with nonzero slot");

    // One word at a time: no accept right after an accept
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("word accepted while busy");

endmodule

`default_nettype wire

// ===== tb/sv/periodic_timer_slot_table_test.sv =====
// Self-checking testbench for periodic_timer_slot_table: directed and random add,
// remove and tick words against a built-in predictor of the slot table.
// Depends on pts_pkg and the periodic_timer_slot_table RTL.
`default_nettype none

module periodic_timer_slot_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 80;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    pts_pkg::in_word_t  in_word = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    pts_pkg::out_word_t out_word;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_data = 16'd1;

    // Predictor copy of the table
    logic [15:0] tick_interval_q;
    logic [31:0] now_ticks_q;
    logic [31:0] cb_q [SLOTS];
    logic [31:0] period_q [SLOTS];
    logic [31:0] deadline_q [SLOTS];
    logic [31:0] args_q [SLOTS][4];
    logic [31:0] proc_q [SLOTS];
    logic [31:0] thr_q [SLOTS];

    pts_pkg::out_word_t pending_results [$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          results_checked = 0;
    logic [31:0] owner_proc [3];
    logic [31:0] owner_thr [3];

    periodic_timer_slot_table #(.SLOT_COUNT(SLOTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word(out_word),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        pts_pkg::out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %p", out_word));
            else
            begin
                e = pending_results.pop_front();
                results_checked++;
                if (out_word.kind !== e.kind)
                    report_mismatch($sformatf("kind %0d exp %0d", out_word.kind, e.kind));
                if (out_word.slot !== e.slot)
                    report_mismatch($sformatf("slot %0d exp %0d", out_word.slot, e.slot));
                if (out_word.fire_addr !== e.fire_addr)
                    report_mismatch($sformatf("fire_addr %h exp %h",
                                              out_word.fire_addr, e.fire_addr));
                if (out_word.fire_a !== e.fire_a)
                    report_mismatch($sformatf("fire_a %h exp %h", out_word.fire_a, e.fire_a));
                if (out_word.fire_b !== e.fire_b)
                    report_mismatch($sformatf("fire_b %h exp %h", out_word.fire_b, e.fire_b));
                if (out_word.fire_c !== e.fire_c)
                    report_mismatch($sformatf("fire_c %h exp %h", out_word.fire_c, e.fire_c));
                if (out_word.fire_d !== e.fire_d)
                    report_mismatch($sformatf("fire_d %h exp %h", out_word.fire_d, e.fire_d));
                if (out_word.last !== e.last)
                    report_mismatch($sformatf("last %0d exp %0d", out_word.last, e.last));
            end
        end
    end

    task automatic reset_table_model();
        tick_interval_q = 16'd1;
        now_ticks_q = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            cb_q[i] = '0;
            period_q[i] = '0;
            deadline_q[i] = '0;
            proc_q[i] = '0;
            thr_q[i] = '0;
            for (int j = 0; j < 4; j++)
                args_q[i][j] = '0;
        end
    endtask

    // Work out the result words one input word causes and queue them
    task automatic predict_timer_word(input pts_pkg::in_word_t w);
        pts_pkg::out_word_t r;
        logic [31:0] div;
        logic [31:0] ticks;
        int          fires;
        bit          placed;
        fires = 0;
        placed = 0;
        r = '0;
        case (w.mode)
            pts_pkg::MODE_ADD:
            begin
                r.kind = pts_pkg::KIND_FAIL;
                r.last = 1'b1;
                div = (tick_interval_q == 16'd0) ? 32'd1 : {16'd0, tick_interval_q};
                if (w.callback_addr != 0 && w.delay != 0)
                begin
                    ticks = w.delay / div + ((w.delay % div) != 0 ? 32'd1 : 32'd0);
                    for (int i = 0; i < SLOTS && !placed; i++)
                    begin
                        if (cb_q[i] == 0 && deadline_q[i] == 0)
                        begin
                            cb_q[i] = w.callback_addr;
                            period_q[i] = ticks;
                            deadline_q[i] = now_ticks_q + ticks;
                            args_q[i][0] = w.arg_a;
                            args_q[i][1] = w.arg_b;
                            args_q[i][2] = w.arg_c;
                            args_q[i][3] = w.arg_d;
                            proc_q[i] = w.task_process;
                            thr_q[i] = w.task_thread;
                            r.kind = pts_pkg::KIND_OK;
                            r.slot = 4'(i);
                            placed = 1;
                        end
                    end
                end
                pending_results.push_back(r);
            end
            pts_pkg::MODE_REMOVE:
            begin
                if (w.slot_index < SLOTS)
                begin
                    cb_q[w.slot_index] = '0;
                    deadline_q[w.slot_index] = '0;
                end
            end
            pts_pkg::MODE_TICK:
            begin
                now_ticks_q = now_ticks_q + 32'd1;
                for (int i = 0; i < SLOTS && fires < pts_pkg::MAX_RESULTS; i++)
                begin
                    if (cb_q[i] != 0 && deadline_q[i] <= now_ticks_q &&
                        proc_q[i] == w.task_process && thr_q[i] == w.task_thread)
                    begin
                        deadline_q[i] = now_ticks_q + period_q[i];
                        r.kind = pts_pkg::KIND_FIRE;
                        r.slot = 4'(i);
                        r.fire_addr = cb_q[i];
                        r.fire_a = args_q[i][0];
                        r.fire_b = args_q[i][1];
                        r.fire_c = args_q[i][2];
                        r.fire_d = args_q[i][3];
                        r.last = 1'b0;
                        pending_results.push_back(r);
                        fires++;
                    end
                end
                if (fires > 0)
                    pending_results[pending_results.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Predict, then hold the word on the input until it is taken
    task automatic send_word(input pts_pkg::in_word_t w);
        predict_timer_word(w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        words_sent++;
    endtask

    // Drop valid, wait out all results and any trailing work
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tick_interval(input logic [15:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tick_interval_q = v;
    endtask

    function automatic pts_pkg::in_word_t make_word(input logic [1:0] m,
                                                    input logic [31:0] cb,
                                                    input logic [31:0] dly,
                                                    input int owner);
        pts_pkg::in_word_t w;
        w.mode = m;
        w.callback_addr = cb;
        w.delay = dly;
        w.arg_a = $urandom;
        w.arg_b = $urandom;
        w.arg_c = $urandom;
        w.arg_d = $urandom;
        w.slot_index = 5'($urandom_range(31));
        w.task_process = owner_proc[owner];
        w.task_thread = owner_thr[owner];
        return w;
    endfunction

    // Rejected adds, deadline wrap, owner mismatch, remove edges, unused mode
    task automatic test_edge_cases();
        pts_pkg::in_word_t w;
        write_tick_interval(16'd1);
        send_word(make_word(pts_pkg::MODE_ADD, 32'd0, 32'd5, 0));
        send_word(make_word(pts_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'd0, 0));
        send_word(make_word(pts_pkg::MODE_TICK, 32'd0, 32'd0, 0));
        w = make_word(pts_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        w.arg_a = '1; w.arg_b = '1; w.arg_c = '1; w.arg_d = '1;
        w.task_process = '1; w.task_thread = '1;
        send_word(w);
        send_word(make_word(pts_pkg::MODE_TICK, 32'd0, 32'd0, 1));
        w.mode = pts_pkg::MODE_TICK;
        send_word(w);
        w.mode = MODE_UNUSED;
        send_word(w);
        w = make_word(pts_pkg::MODE_REMOVE, '0, '0, 0);
        w.slot_index = 5'd31;
        send_word(w);
        w.slot_index = 5'd0;
        send_word(w);
        send_word(make_word(pts_pkg::MODE_TICK, 32'd0, 32'd0, 0));
    endtask

    // Fill all slots, overflow once, fire all sixteen in one tick
    task automatic test_full_table();
        pts_pkg::in_word_t w;
        write_tick_interval(16'd0);
        w = make_word(pts_pkg::MODE_REMOVE, '0, '0, 0);
        for (int i = 0; i < SLOTS; i++)
        begin
            w.slot_index = 5'(i);
            send_word(w);
        end
        for (int i = 0; i <= SLOTS; i++)
            send_word(make_word(pts_pkg::MODE_ADD, $urandom | 32'd1, 32'd1, 0));
        send_word(make_word(pts_pkg::MODE_TICK, '0, '0, 0));
        send_word(make_word(pts_pkg::MODE_TICK, '0, '0, 0));
    endtask

    // Random traffic under one interval; adds mostly from a small owner pool
    task automatic test_random_traffic(input int count, input logic [15:0] interval);
        pts_pkg::in_word_t w;
        int          pick;
        logic [31:0] dly;
        write_tick_interval(interval);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            dly = ($urandom_range(9) == 0) ? $urandom
                  : $urandom_range(1, 4 * ((interval == 0) ? 1 : interval));
            if (pick < 35)
                w = make_word(pts_pkg::MODE_ADD,
                              ($urandom_range(19) == 0) ? 32'd0 : $urandom,
                              ($urandom_range(19) == 0) ? 32'd0 : dly, $urandom_range(2));
            else if (pick < 55)
            begin
                w = make_word(pts_pkg::MODE_REMOVE, $urandom, $urandom, $urandom_range(2));
                if ($urandom_range(4) != 0)
                    w.slot_index = 5'($urandom_range(SLOTS - 1));
            end
            else if (pick < 95)
                w = make_word(pts_pkg::MODE_TICK, $urandom, $urandom, $urandom_range(2));
            else
                w = make_word(MODE_UNUSED, $urandom, $urandom, $urandom_range(2));
            if ($urandom_range(15) == 0)
            begin
                w.task_process = $urandom;
                w.task_thread = $urandom;
            end
            send_word(w);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            owner_proc[i] = $urandom;
            owner_thr[i] = $urandom;
        end
        reset_table_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_stall_pct = 57;
        test_edge_cases();
        test_full_table();
        test_random_traffic(110, 16'd1);
        send_idle_pct = 57;
        recv_stall_pct = 29;
        test_random_traffic(110, 16'hFFFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_traffic(50, 16'($urandom_range(2, 1000)));
        test_random_traffic(40, 16'd3);
        wait_idle();

        $display("Covered %0d input words and %0d result words over interval",
                 words_sent, results_checked);
        $display("settings 0, 1, 65535 and random, with add, remove, tick and unused mode.");
        if (mismatch_count == 0)
            $display("periodic_timer_slot_table regression: pass");
        else
            $display("periodic_timer_slot_table regression: fail");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #20ms;
        $display("periodic_timer_slot_table regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/pts_pkg.sv
rtl/pts_ctrl.sv
rtl/pts_dp.sv
rtl/periodic_timer_slot_table.sv
tb/sv/periodic_timer_slot_table_test.sv
